// ===== src/etq_pkg.sv =====
package etq_pkg;

  // Default build values
  localparam int DEF_SINE_TABLE_DEPTH     = 1024;
  localparam int DEF_OUTPUT_FRACTION_BITS = 14;

  // Field widths
  localparam int ANGLE_W    = 16;
  localparam int QUAT_W     = 16;
  localparam int IN_DATA_W  = 3 * ANGLE_W;
  localparam int OUT_DATA_W = 4 * QUAT_W;

  // Internal number formats: sine/cosine and rounded pairs in signed Q30,
  // raw products in signed Q60
  localparam int TRIG_W    = 32;
  localparam int PROD_W    = 64;
  localparam int Q30_SHIFT = 30;
  localparam int Q60_SHIFT = 60;

  // Register stages from input transaction to output register:
  // six in the angle cells, two in the pair cells, four in the term cells
  localparam int PIPE_DEPTH = 12;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [QUAT_W-1:0] quat_t;

  // Shift right by sh with rounding half away from zero
  function automatic prod_t round_away(input prod_t v, input int unsigned sh);
    prod_t half;
    prod_t adj;
    half = prod_t'(1) <<< (sh - 1);
    adj  = v + half - (v[PROD_W-1] ? prod_t'(1) : prod_t'(0));
    return adj >>> sh;
  endfunction

endpackage

// ===== src/etq_angle_cell.sv =====
module etq_angle_cell #(
  parameter int SINE_TABLE_DEPTH = etq_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [etq_pkg::ANGLE_W-1:0] angle,
  output etq_pkg::trig_t                    sin_half,
  output etq_pkg::trig_t                    cos_half
);

  localparam int ANGLE_LIMIT  = 23040;
  localparam int QUARTER_TURN = 23040;
  localparam int MAG_W        = $clog2(ANGLE_LIMIT + 1);
  localparam int NUM_W        = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + QUARTER_TURN / 2 + 1);
  // 23040 = 512 * 45: shift out 512, then divide by 45 through a reciprocal
  localparam int DIV_SHIFT    = 9;
  localparam int DIV_ODD      = 45;
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP        = (1 << RECIP_SHIFT) / DIV_ODD;
  localparam int RECIP_W      = $clog2(RECIP + 1);
  localparam int Q_W          = NUM_W - DIV_SHIFT;
  localparam int IDX_W        = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ROM_W        = etq_pkg::Q30_SHIFT + 1;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic signed [etq_pkg::ANGLE_W-1:0] LIMIT_POS = etq_pkg::ANGLE_W'(ANGLE_LIMIT);
  localparam logic signed [etq_pkg::ANGLE_W-1:0] LIMIT_NEG = -etq_pkg::ANGLE_W'(ANGLE_LIMIT);

  typedef logic [ROM_W-1:0] rom_t [SINE_TABLE_DEPTH+1];

  // Sine of a Q30 angle in radians by a truncating Taylor series
  function automatic logic [ROM_W-1:0] sine_q30(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n < 20; n++) begin
      term = (term * x) >> etq_pkg::Q30_SHIFT;
      term = (term * x) >> etq_pkg::Q30_SHIFT;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< etq_pkg::Q30_SHIFT)) begin
      sum = 64'sd1 <<< etq_pkg::Q30_SHIFT;
    end
    return ROM_W'(sum);
  endfunction

  // Quarter-wave sine table, entry k at k quarter turns over the depth
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (64'(k) * PI_HALF_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      r[k] = sine_q30(x);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [MAG_W-1:0]   mag1;
  logic               neg1, neg2, neg3, neg4, neg5;
  logic [NUM_W-1:0]   num2;
  logic [Q_W-1:0]     q3;
  logic [IDX_W-1:0]   est3;
  logic [IDX_W-1:0]   idx4;
  logic [ROM_W-1:0]   sin_mag5;
  logic [ROM_W-1:0]   cos_mag5;
  logic signed [etq_pkg::ANGLE_W-1:0] clamped;
  logic [NUM_W-1:0]   num_next;
  logic [Q_W-1:0]     q_next;
  logic [Q_W+RECIP_W-1:0] recip_prod;
  logic [Q_W-1:0]     rem;
  logic [IDX_W-1:0]   idx_next;
  logic [IDX_W-1:0]   cos_idx;

  // Saturate to a half turn either way
  always_comb begin
    if (angle > LIMIT_POS) begin
      clamped = LIMIT_POS;
    end else if (angle < LIMIT_NEG) begin
      clamped = LIMIT_NEG;
    end else begin
      clamped = angle;
    end
  end

  // Scale the magnitude to table steps with half a step for rounding
  assign num_next   = NUM_W'(mag1) * NUM_W'(SINE_TABLE_DEPTH) + NUM_W'(QUARTER_TURN / 2);

  // Estimate the quotient; it is exact or one short
  assign q_next     = Q_W'(num2 >> DIV_SHIFT);
  assign recip_prod = (Q_W+RECIP_W)'(q_next) * (Q_W+RECIP_W)'(RECIP);

  // Correct the estimate by one compare
  assign rem      = q3 - Q_W'(est3) * Q_W'(DIV_ODD);
  assign idx_next = (rem >= Q_W'(DIV_ODD)) ? est3 + IDX_W'(1) : est3;
  assign cos_idx  = IDX_W'(SINE_TABLE_DEPTH) - idx4;

  always_ff @(posedge clk) begin
    if (en) begin
      mag1     <= MAG_W'(clamped[etq_pkg::ANGLE_W-1] ? -clamped : clamped);
      neg1     <= clamped[etq_pkg::ANGLE_W-1];
      num2     <= num_next;
      neg2     <= neg1;
      q3       <= q_next;
      est3     <= IDX_W'(recip_prod >> RECIP_SHIFT);
      neg3     <= neg2;
      idx4     <= idx_next;
      neg4     <= neg3;
      sin_mag5 <= SINE_ROM[idx4];
      cos_mag5 <= SINE_ROM[cos_idx];
      neg5     <= neg4;
      sin_half <= neg5 ? -etq_pkg::trig_t'(sin_mag5) : etq_pkg::trig_t'(sin_mag5);
      cos_half <= etq_pkg::trig_t'(cos_mag5);
    end
  end

endmodule

// ===== src/etq_pair_cell.sv =====
module etq_pair_cell (
  input  logic           clk,
  input  logic           en,
  input  etq_pkg::trig_t a,
  input  etq_pkg::trig_t b,
  output etq_pkg::trig_t pair
);

  etq_pkg::prod_t prod;

  // Multiply, then round the Q60 product back to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= etq_pkg::prod_t'(a) * etq_pkg::prod_t'(b);
      pair <= etq_pkg::TRIG_W'(etq_pkg::round_away(prod, etq_pkg::Q30_SHIFT));
    end
  end

endmodule

// ===== src/etq_term_cell.sv =====
module etq_term_cell #(
  parameter int OUTPUT_FRACTION_BITS = etq_pkg::DEF_OUTPUT_FRACTION_BITS,
  parameter bit SUBTRACT             = 1'b0
) (
  input  logic           clk,
  input  logic           en,
  input  etq_pkg::trig_t pair_a,
  input  etq_pkg::trig_t coef_a,
  input  etq_pkg::trig_t pair_b,
  input  etq_pkg::trig_t coef_b,
  output etq_pkg::quat_t quat
);

  localparam int ROUND_SHIFT = etq_pkg::Q60_SHIFT - OUTPUT_FRACTION_BITS;
  localparam etq_pkg::prod_t SAT_HI = etq_pkg::prod_t'((1 << (etq_pkg::QUAT_W - 1)) - 1);
  localparam etq_pkg::prod_t SAT_LO = -etq_pkg::prod_t'(1 << (etq_pkg::QUAT_W - 1));

  etq_pkg::prod_t term_a, term_b, sum, rnd;

  // Two Q60 terms, exact sum, round to the output format, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      term_a <= etq_pkg::prod_t'(pair_a) * etq_pkg::prod_t'(coef_a);
      term_b <= etq_pkg::prod_t'(pair_b) * etq_pkg::prod_t'(coef_b);
      sum    <= SUBTRACT ? term_a - term_b : term_a + term_b;
      rnd    <= etq_pkg::round_away(sum, ROUND_SHIFT);
      if (rnd > SAT_HI) begin
        quat <= etq_pkg::QUAT_W'(SAT_HI);
      end else if (rnd < SAT_LO) begin
        quat <= etq_pkg::QUAT_W'(SAT_LO);
      end else begin
        quat <= etq_pkg::QUAT_W'(rnd);
      end
    end
  end

endmodule

// ===== src/euler_to_quaternion.sv =====
// Euler angle (yaw * pitch * roll, Z-Y-X) to unit quaternion converter.
//
// Input channel s_axis: one transaction carries roll, pitch and yaw, each a
// signed count of 1/128 degree, saturated to a half turn either way.
// Output channel m_axis: one transaction per input transaction carries
// w, x, y, z in signed fixed point with OUTPUT_FRACTION_BITS fraction bits.
//
// Throughput: one transaction per cycle while the receiver takes results.
// Input acceptance to m_axis_tvalid passes the register row: six angle-cell
// stages (clamp, scale, divide, correct, table read, sign), two pair-cell
// stages (multiply, round) and four term-cell stages (multiply, add,
// round, saturate). A transaction may wait in the skid register first.
// Each angle cell reads its own sine table at two addresses per cycle.
//
// Reset (rst, synchronous) empties the pipeline and the skid register; no
// table clearing is needed. When the receiver stalls, the whole row holds,
// the skid register takes one more transaction, then s_axis_tready drops.
module euler_to_quaternion #(
  parameter int SINE_TABLE_DEPTH     = etq_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int OUTPUT_FRACTION_BITS = etq_pkg::DEF_OUTPUT_FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] roll, [31:16] pitch, [47:32] yaw
  input  logic [etq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z
  output logic [etq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int AW = etq_pkg::ANGLE_W;

  logic                           skid_valid;
  logic [etq_pkg::IN_DATA_W-1:0]  skid_data;
  logic [etq_pkg::PIPE_DEPTH-1:0] vld;
  logic                           adv;
  logic                           src_valid;
  logic [etq_pkg::IN_DATA_W-1:0]  src_data;

  etq_pkg::trig_t sr, cr, sp, cp, sy, cy;
  etq_pkg::trig_t sr_d1, sr_d2, cr_d1, cr_d2;
  etq_pkg::trig_t p_cycp, p_sysp, p_cysp, p_sycp;
  etq_pkg::quat_t quat_w, quat_x, quat_y, quat_z;

  // Advance the row unless the output register holds an untaken result
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !skid_valid;
  assign src_valid     = skid_valid || s_axis_tvalid;
  assign src_data      = skid_valid ? skid_data : s_axis_tdata;
  assign m_axis_tvalid = vld[etq_pkg::PIPE_DEPTH-1];
  assign m_axis_tdata  = {quat_z, quat_y, quat_x, quat_w};

  // Valid flags and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      skid_valid <= 1'b0;
    end else begin
      if (adv) begin
        vld        <= {vld[etq_pkg::PIPE_DEPTH-2:0], src_valid};
        skid_valid <= 1'b0;
      end else if (s_axis_tvalid && s_axis_tready) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Capture a transaction that arrives while the row holds
  always_ff @(posedge clk) begin
    if (s_axis_tready && !adv) begin
      skid_data <= s_axis_tdata;
    end
  end

  etq_angle_cell #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_roll (
    .clk(clk), .en(adv), .angle($signed(src_data[AW-1:0])),
    .sin_half(sr), .cos_half(cr)
  );
  etq_angle_cell #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_pitch (
    .clk(clk), .en(adv), .angle($signed(src_data[2*AW-1:AW])),
    .sin_half(sp), .cos_half(cp)
  );
  etq_angle_cell #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_yaw (
    .clk(clk), .en(adv), .angle($signed(src_data[3*AW-1:2*AW])),
    .sin_half(sy), .cos_half(cy)
  );

  // Delay roll terms to meet the rounded yaw-pitch pairs
  always_ff @(posedge clk) begin
    if (adv) begin
      sr_d1 <= sr;
      sr_d2 <= sr_d1;
      cr_d1 <= cr;
      cr_d2 <= cr_d1;
    end
  end

  etq_pair_cell u_cycp (.clk(clk), .en(adv), .a(cy), .b(cp), .pair(p_cycp));
  etq_pair_cell u_sysp (.clk(clk), .en(adv), .a(sy), .b(sp), .pair(p_sysp));
  etq_pair_cell u_cysp (.clk(clk), .en(adv), .a(cy), .b(sp), .pair(p_cysp));
  etq_pair_cell u_sycp (.clk(clk), .en(adv), .a(sy), .b(cp), .pair(p_sycp));

  // w = cy*cp*cr + sy*sp*sr
  etq_term_cell #(.OUTPUT_FRACTION_BITS(OUTPUT_FRACTION_BITS), .SUBTRACT(1'b0)) u_w (
    .clk(clk), .en(adv), .pair_a(p_cycp), .coef_a(cr_d2),
    .pair_b(p_sysp), .coef_b(sr_d2), .quat(quat_w)
  );
  // x = cy*cp*sr - sy*sp*cr
  etq_term_cell #(.OUTPUT_FRACTION_BITS(OUTPUT_FRACTION_BITS), .SUBTRACT(1'b1)) u_x (
    .clk(clk), .en(adv), .pair_a(p_cycp), .coef_a(sr_d2),
    .pair_b(p_sysp), .coef_b(cr_d2), .quat(quat_x)
  );
  // y = cy*sp*cr + sy*cp*sr
  etq_term_cell #(.OUTPUT_FRACTION_BITS(OUTPUT_FRACTION_BITS), .SUBTRACT(1'b0)) u_y (
    .clk(clk), .en(adv), .pair_a(p_cysp), .coef_a(cr_d2),
    .pair_b(p_sycp), .coef_b(sr_d2), .quat(quat_y)
  );
  // z = sy*cp*cr - cy*sp*sr
  etq_term_cell #(.OUTPUT_FRACTION_BITS(OUTPUT_FRACTION_BITS), .SUBTRACT(1'b1)) u_z (
    .clk(clk), .en(adv), .pair_a(p_sycp), .coef_a(cr_d2),
    .pair_b(p_cysp), .coef_b(sr_d2), .quat(quat_z)
  );

endmodule

// ===== src/etq_checker.sv =====
module etq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [etq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [etq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // Reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output valid or input stalled after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  // Input backpressure only follows an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // Skid drains as soon as the output moves
  a_ready_return: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready && (!m_axis_tvalid || m_axis_tready) |=> s_axis_tready)
    else $error("input stayed stalled after the output moved");

endmodule

bind euler_to_quaternion etq_checker u_checker (.*);

// ===== bench/testbench.sv =====
module testbench;

  localparam int      TABLE_DEPTH  = etq_pkg::DEF_SINE_TABLE_DEPTH;
  localparam int      FRAC_BITS    = etq_pkg::DEF_OUTPUT_FRACTION_BITS;
  localparam int      ANGLE_MAX    = 23040;
  localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint  UNIT_Q30     = 64'sd1073741824;
  localparam int      MAX_WAIT     = 17;
  localparam int      PHASES       = 12;
  localparam int      PHASE_ITEMS  = 160;
  // Worst gap between two transactions is far below this
  localparam int      IDLE_LIMIT   = 1000;

  typedef struct packed {
    etq_pkg::quat_t z;
    etq_pkg::quat_t y;
    etq_pkg::quat_t x;
    etq_pkg::quat_t w;
  } quat_rec_t;

  // Quaternion predictor and queue of quaternions still owed by the block
  class quat_tracker;
    longint    sine_rom[TABLE_DEPTH+1];
    quat_rec_t owed[$];
    int        bad_count;

    function new();
      bit [63:0] ang;
      bit [63:0] term;
      bit [63:0] n;
      longint    acc;
      bad_count = 0;
      // Fill quarter-wave sine table with a truncated Taylor series
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
        ang  = (64'(k) * HALF_PI_Q30 + 64'(TABLE_DEPTH / 2)) / 64'(TABLE_DEPTH);
        term = ang;
        acc  = longint'(ang);
        for (n = 1; n < 20 && term != 0; n++) begin
          term = (term * ang) >> 30;
          term = (term * ang) >> 30;
          term = term / ((2 * n) * (2 * n + 1));
          if (n[0])
            acc = acc - longint'(term);
          else
            acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > UNIT_Q30) acc = UNIT_Q30;
        sine_rom[k] = acc;
      end
    endfunction

    // Shift right with rounding half away from zero
    function etq_pkg::prod_t round_off(input etq_pkg::prod_t v, input int unsigned sh);
      bit        neg;
      bit [63:0] mag;
      neg = v < 0;
      mag = neg ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return neg ? -etq_pkg::prod_t'(mag) : etq_pkg::prod_t'(mag);
    endfunction

    // Sine and cosine of the half angle held in one input field
    function void half_sincos(input logic signed [15:0] raw,
                              output etq_pkg::trig_t s,
                              output etq_pkg::trig_t c);
      int a;
      int mag;
      int idx;
      a = raw;
      if (a > ANGLE_MAX) a = ANGLE_MAX;
      if (a < -ANGLE_MAX) a = -ANGLE_MAX;
      mag = (a < 0) ? -a : a;
      idx = (mag * TABLE_DEPTH + ANGLE_MAX / 2) / ANGLE_MAX;
      if (idx > TABLE_DEPTH) idx = TABLE_DEPTH;
      s = (a < 0) ? etq_pkg::trig_t'(-sine_rom[idx]) : etq_pkg::trig_t'(sine_rom[idx]);
      c = etq_pkg::trig_t'(sine_rom[TABLE_DEPTH - idx]);
    endfunction

    function etq_pkg::prod_t mul3(input etq_pkg::trig_t a, input etq_pkg::trig_t b,
                                  input etq_pkg::trig_t c);
      return round_off(etq_pkg::prod_t'(a) * etq_pkg::prod_t'(b), etq_pkg::Q30_SHIFT)
             * etq_pkg::prod_t'(c);
    endfunction

    // Round Q60 sum to output format and saturate
    function etq_pkg::quat_t to_output(input etq_pkg::prod_t q60);
      etq_pkg::prod_t v;
      v = round_off(q60, etq_pkg::Q60_SHIFT - FRAC_BITS);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return etq_pkg::quat_t'(v[15:0]);
    endfunction

    function quat_rec_t compose_zyx(input logic [etq_pkg::IN_DATA_W-1:0] angles);
      etq_pkg::trig_t sr, cr, sp, cp, sy, cy;
      quat_rec_t      q;
      half_sincos(angles[15:0], sr, cr);
      half_sincos(angles[31:16], sp, cp);
      half_sincos(angles[47:32], sy, cy);
      q.w = to_output(mul3(cy, cp, cr) + mul3(sy, sp, sr));
      q.x = to_output(mul3(cy, cp, sr) - mul3(sy, sp, cr));
      q.y = to_output(mul3(cy, sp, cr) + mul3(sy, cp, sr));
      q.z = to_output(mul3(sy, cp, cr) - mul3(cy, sp, sr));
      return q;
    endfunction

    function void note_sample(input logic [etq_pkg::IN_DATA_W-1:0] angles);
      owed = {owed, compose_zyx(angles)};
    endfunction

    function void check_result(input logic [etq_pkg::OUT_DATA_W-1:0] data);
      quat_rec_t got;
      quat_rec_t want;
      got = data;
      if (owed.size() == 0) begin
        $display("%0t: unexpected quaternion %h", $time, data);
        bad_count++;
        return;
      end
      want = owed.pop_front();
      if (got.w !== want.w) begin
        $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
        bad_count++;
      end
      if (got.x !== want.x) begin
        $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
        bad_count++;
      end
      if (got.y !== want.y) begin
        $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
        bad_count++;
      end
      if (got.z !== want.z) begin
        $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
        bad_count++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [etq_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [etq_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  quat_tracker tracker = new();
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int          idle_cycles = 0;

  euler_to_quaternion dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record accepted attitudes, check accepted quaternions, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Receiver: stall a random number of cycles before each quaternion when rx_gaps is set
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Offer one attitude, after a random gap when tx_gaps is set, and hold it until accepted
  task automatic send_attitude(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {yaw, pitch, roll};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold off the sender until every owed quaternion has come back
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.owed.size() != 0);
    @(posedge clk);
  endtask

  // Mostly in-range angles, some raw 16-bit words and the corner values
  function automatic logic [15:0] pick_angle();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
    end else if (r < 85) begin
      v = $urandom();
    end else begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = ANGLE_MAX;
        2: v = -ANGLE_MAX;
        3: v = ANGLE_MAX / 2;
        4: v = -ANGLE_MAX / 2;
        default: v = int'($urandom_range(0, 40)) - 20;
      endcase
    end
    return v[15:0];
  endfunction

  initial begin
    logic [15:0] corner_set [22][3];
    corner_set = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd23040, 16'sd0, 16'sd0},
      '{-16'sd23040, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd23040, 16'sd0},
      '{16'sd0, -16'sd23040, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd23040},
      '{16'sd0, 16'sd0, -16'sd23040},
      '{16'sd23040, 16'sd23040, 16'sd23040},
      '{-16'sd23040, -16'sd23040, -16'sd23040},
      '{16'sd32767, -16'sd32768, 16'sd23041},
      '{-16'sd23041, 16'sd32767, -16'sd32768},
      '{16'sd11520, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd11520, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd11520},
      '{16'sd11520, 16'sd11520, 16'sd11520},
      '{-16'sd11520, 16'sd5760, -16'sd17280},
      '{16'sd1, -16'sd1, 16'sd11},
      '{16'sd12, -16'sd12, 16'sd34},
      '{16'sd23039, -16'sd23039, 16'sd22},
      '{16'h5555, 16'hAAAA, 16'h5555},
      '{16'hAAAA, 16'h5555, 16'hAAAA},
      '{-16'sd1, -16'sd1, -16'sd1}
    };

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: limits, saturation, right angles, near-zero angles
    foreach (corner_set[i])
      send_attitude(corner_set[i][0], corner_set[i][1], corner_set[i][2]);
    drain_pipeline();

    // Random attitudes, idling mode changes per phase
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_gaps = 1'b1; rx_gaps = 1'b1; end
        1: begin tx_gaps = 1'b0; rx_gaps = 1'b0; end
        2: begin tx_gaps = 1'b0; rx_gaps = 1'b1; end
        default: begin tx_gaps = 1'b1; rx_gaps = 1'b0; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_attitude(pick_angle(), pick_angle(), pick_angle());
      if (p == PHASES / 2) drain_pipeline();
    end

    // Let the pipeline empty, then allow for any stray output
    drain_pipeline();
    repeat (etq_pkg::PIPE_DEPTH + 4) @(posedge clk);
    if (tracker.owed.size() != 0)
      $display("%0t: %0d quaternions never came", $time, tracker.owed.size());
    if (tracker.bad_count == 0 && tracker.owed.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
